// ----- sv/sfr_pkg.sv -----
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int PAT_CAP         = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
    localparam int REP_CAP         = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;
    localparam int MAX_RESULTS     = 8;

    localparam int FILL_W  = $clog2(PAT_CAP + 1);
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int BYTES_W = 8 * MAX_RESULTS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } sfr_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       end_of_text;
    } sfr_out_t;

    // one command: a run of result bytes, oldest in bits 7:0
    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [CNT_W-1:0]   count;
        logic               present;
        logic               end_mark;
    } sfr_cmd_t;

    typedef struct packed {
        logic     push;
        logic     full;
        sfr_cmd_t cmd;
    } sfr_qin_t;

endpackage

// ----- sv/sfr_front.sv -----
`timescale 1ns / 1ps

module sfr_front
    import sfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  sfr_in_t                source_item,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  logic                   queue_full,
    output sfr_qin_t               qin
);

    logic [63:0]       pattern_bytes_reg, pattern_bytes_next;
    logic [3:0]        pattern_length_reg, pattern_length_next;
    logic [63:0]       replacement_bytes_reg, replacement_bytes_next;
    logic [3:0]        replacement_length_reg, replacement_length_next;
    logic [7:0]        win_reg  [PAT_CAP];
    logic [7:0]        win_next [PAT_CAP];
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic [7:0]         win_cur   [PAT_CAP];
    logic [7:0]         win_shift [PAT_CAP];
    logic [BYTES_W-1:0] win_packed;
    logic [FILL_W-1:0]  plen;
    logic [CNT_W-1:0]   rlen;
    logic [FILL_W-1:0]  fill_eff;
    logic [FILL_W-1:0]  new_fill;
    logic               accept;
    logic               same;
    logic               window_full;
    sfr_cmd_t           cmd;
    logic               cmd_push;

    assign full   = queue_full;
    assign accept = push && !queue_full;

    always_comb
    begin
        if (pattern_length_reg == 4'd0)
        begin
            plen = FILL_W'(1);
        end
        else if (int'(pattern_length_reg) > PAT_CAP)
        begin
            plen = FILL_W'(PAT_CAP);
        end
        else
        begin
            plen = FILL_W'(pattern_length_reg);
        end
        if (int'(replacement_length_reg) > REP_CAP)
        begin
            rlen = CNT_W'(REP_CAP);
        end
        else
        begin
            rlen = CNT_W'(replacement_length_reg);
        end
    end

    always_comb
    begin
        fill_eff   = (fill_reg >= plen) ? '0 : fill_reg;
        new_fill   = fill_eff + FILL_W'(1);
        same       = 1'b1;
        win_packed = '0;
        for (int i = 0; i < PAT_CAP; i++)
        begin
            win_cur[i] = (FILL_W'(i) == fill_eff) ? source_item.text_byte : win_reg[i];
        end
        for (int i = 0; i < PAT_CAP; i++)
        begin
            if (FILL_W'(i) < plen && win_cur[i] != pattern_bytes_reg[8*i +: 8])
            begin
                same = 1'b0;
            end
            win_packed[8*i +: 8] = win_cur[i];
        end
        for (int i = 0; i < PAT_CAP - 1; i++)
        begin
            win_shift[i] = win_cur[i + 1];
        end
        win_shift[PAT_CAP-1] = 8'd0;
        window_full = (new_fill == plen);
    end

    // classify the byte into at most one command
    always_comb
    begin
        cmd.bytes    = win_packed;
        cmd.count    = CNT_W'(1);
        cmd.present  = 1'b1;
        cmd.end_mark = source_item.final_byte;
        cmd_push     = 1'b0;
        fill_next    = fill_reg;
        win_next     = win_reg;
        if (accept)
        begin
            priority if (window_full && same)
            begin
                fill_next = '0;
                if (rlen != '0)
                begin
                    cmd.bytes = BYTES_W'(replacement_bytes_reg);
                    cmd.count = rlen;
                    cmd_push  = 1'b1;
                end
                else if (source_item.final_byte)
                begin
                    cmd.bytes   = '0;
                    cmd.present = 1'b0;
                    cmd_push    = 1'b1;
                end
            end
            else if (source_item.final_byte)
            begin
                // flush the whole window
                cmd.count = CNT_W'(new_fill);
                cmd_push  = 1'b1;
                fill_next = '0;
            end
            else if (window_full)
            begin
                cmd_push  = 1'b1;
                win_next  = win_shift;
                fill_next = plen - FILL_W'(1);
            end
            else
            begin
                win_next  = win_cur;
                fill_next = new_fill;
            end
        end
    end

    always_comb
    begin
        pattern_bytes_next      = pattern_bytes_reg;
        pattern_length_next     = pattern_length_reg;
        replacement_bytes_next  = replacement_bytes_reg;
        replacement_length_next = replacement_length_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_PATTERN_BYTES:      pattern_bytes_next      = wr_data[63:0];
                REG_PATTERN_LENGTH:     pattern_length_next     = wr_data[3:0];
                REG_REPLACEMENT_BYTES:  replacement_bytes_next  = wr_data[63:0];
                REG_REPLACEMENT_LENGTH: replacement_length_next = wr_data[3:0];
                default:                pattern_bytes_next      = pattern_bytes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= 4'd1;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
            fill_reg               <= '0;
            for (int i = 0; i < PAT_CAP; i++)
            begin
                win_reg[i] <= 8'd0;
            end
        end
        else
        begin
            pattern_bytes_reg      <= pattern_bytes_next;
            pattern_length_reg     <= pattern_length_next;
            replacement_bytes_reg  <= replacement_bytes_next;
            replacement_length_reg <= replacement_length_next;
            win_reg                <= win_next;
            if (wr_en && wr_index == REG_PATTERN_LENGTH)
            begin
                fill_reg <= '0;
            end
            else
            begin
                fill_reg <= fill_next;
            end
        end
    end

    assign qin.push = cmd_push;
    assign qin.full = queue_full;
    assign qin.cmd  = cmd;

`ifndef SYNTH
    a_fill_below_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < plen)
        else $error("window fill reached pattern length");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !queue_full)
        else $error("command pushed into full queue");
`endif

endmodule

// ----- sv/sfr_cmd_queue.sv -----
`timescale 1ns / 1ps

module sfr_cmd_queue
    import sfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sfr_qin_t qin,
    output logic     queue_full,
    input  logic     take,
    output logic     queue_empty,
    output sfr_cmd_t head
);

    sfr_cmd_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign queue_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign queue_empty = (count_reg == '0);
    assign head        = slot_reg[rd_ptr_reg];
    assign do_push     = qin.push && !queue_full;
    assign do_pop      = take && !queue_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= qin.cmd;
        end
    end

`ifndef SYNTH
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_pointers_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ----- sv/sfr_back.sv -----
`timescale 1ns / 1ps

module sfr_back
    import sfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     queue_empty,
    input  sfr_cmd_t head,
    output logic     take,
    output logic     empty,
    input  logic     pop,
    output sfr_out_t result_item
);

    logic               cur_valid_reg, cur_valid_next;
    logic [BYTES_W-1:0] cur_bytes_reg, cur_bytes_next;
    logic [CNT_W-1:0]   cur_rem_reg, cur_rem_next;
    logic               cur_present_reg, cur_present_next;
    logic               cur_end_reg, cur_end_next;
    logic               last_of_cmd;
    logic               finishing;

    assign last_of_cmd = (cur_rem_reg == CNT_W'(1));
    assign finishing   = cur_valid_reg && pop && last_of_cmd;
    assign take        = (!cur_valid_reg || finishing) && !queue_empty;

    always_comb
    begin
        cur_valid_next   = cur_valid_reg;
        cur_bytes_next   = cur_bytes_reg;
        cur_rem_next     = cur_rem_reg;
        cur_present_next = cur_present_reg;
        cur_end_next     = cur_end_reg;
        priority if (take)
        begin
            cur_valid_next   = 1'b1;
            cur_bytes_next   = head.bytes;
            cur_rem_next     = head.count;
            cur_present_next = head.present;
            cur_end_next     = head.end_mark;
        end
        else if (finishing)
        begin
            cur_valid_next = 1'b0;
        end
        else if (cur_valid_reg && pop)
        begin
            cur_bytes_next = cur_bytes_reg >> 8;
            cur_rem_next   = cur_rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_rem_reg   <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cur_rem_reg   <= cur_rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_bytes_reg   <= cur_bytes_next;
        cur_present_reg <= cur_present_next;
        cur_end_reg     <= cur_end_next;
    end

    assign empty                    = !cur_valid_reg;
    assign result_item.out_byte     = cur_bytes_reg[7:0];
    assign result_item.byte_present = cur_present_reg;
    assign result_item.end_of_text  = cur_end_reg && last_of_cmd;

`ifndef SYNTH
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> cur_rem_reg != '0)
        else $error("active command with no bytes left");

    a_partial_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && pop && !last_of_cmd) |=> cur_valid_reg)
        else $error("command dropped before its last byte");
`endif

endmodule

// ----- sv/stream_find_replace_core.sv -----
`timescale 1ns / 1ps

// Byte-stream find and replace. Every leftmost, non-overlapping occurrence of
// the pattern (1 to 8 bytes) is rewritten as the replacement (0 to 8 bytes);
// the byte flagged final flushes the window and the last result of the text
// carries end_of_text (a bare end mark with byte_present low when nothing is
// left to send). Input takes one byte per cycle while the four-entry command
// queue between the classifier and the output serializer has room. Output
// gives one result per cycle while pop is high and results wait; a byte that
// completes a match or ends the text releases up to 8 results, so sustained
// input rate is set by the serializer when replacements expand the text. The
// user must write configuration only while the block is idle, which the block
// does not enforce; writing the pattern length discards bytes in the window.

module stream_find_replace_core
    import sfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  sfr_in_t                source_item,
    output logic                   empty,
    input  logic                   pop,
    output sfr_out_t               result_item,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    sfr_qin_t qin;
    sfr_cmd_t head;
    logic     queue_full;
    logic     queue_empty;
    logic     take;

    sfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .source_item (source_item),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .queue_full  (queue_full),
        .qin         (qin)
    );

    sfr_cmd_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .qin         (qin),
        .queue_full  (queue_full),
        .take        (take),
        .queue_empty (queue_empty),
        .head        (head)
    );

    sfr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .take        (take),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import sfr_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 44;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   push        = 1'b0;
    logic                   full;
    sfr_in_t                source_item = '0;
    logic                   empty;
    logic                   pop         = 1'b0;
    sfr_out_t               result_item;
    logic                   wr_en       = 1'b0;
    logic [CFG_INDEX_W-1:0] wr_index    = '0;
    logic [CFG_DATA_W-1:0]  wr_data     = '0;

    // mirror of the block state
    logic [63:0] pat_bytes_r = '0;
    logic [3:0]  pat_len_r   = 4'd1;
    logic [63:0] rep_bytes_r = '0;
    logic [3:0]  rep_len_r   = 4'd0;
    logic [7:0]  held_bytes [PAT_CAP];
    int          held_count  = 0;

    sfr_in_t  pending_q [$];
    sfr_out_t rewritten_q [$];

    int errors         = 0;
    int cycles         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    int send_modes [4] = '{0, 45, 0, 24};
    int recv_modes [4] = '{0, 0, 45, 24};

    stream_find_replace_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .source_item (source_item),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pat_len_eff();
        int n;
        n = int'(pat_len_r);
        if (n == 0)
            n = 1;
        if (n > PAT_CAP)
            n = PAT_CAP;
        return n;
    endfunction

    function automatic int rep_len_eff();
        int n;
        n = int'(rep_len_r);
        if (n > REP_CAP)
            n = REP_CAP;
        return n;
    endfunction

    function automatic void emit(logic [7:0] b, logic present, logic eot);
        sfr_out_t r;
        r.out_byte     = b;
        r.byte_present = present;
        r.end_of_text  = eot;
        rewritten_q.push_back(r);
    endfunction

    function automatic void apply_write(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PATTERN_BYTES:
                pat_bytes_r = val;
            REG_PATTERN_LENGTH:
            begin
                pat_len_r  = val[3:0];
                held_count = 0;
            end
            REG_REPLACEMENT_BYTES:
                rep_bytes_r = val;
            REG_REPLACEMENT_LENGTH:
                rep_len_r = val[3:0];
            default:
                ;
        endcase
    endfunction

    function automatic void rewrite_byte(sfr_in_t item);
        int plen;
        int rlen;
        int sent;
        bit same;
        plen = pat_len_eff();
        rlen = rep_len_eff();
        sent = 0;
        if (held_count >= plen)
            held_count = 0;
        held_bytes[held_count] = item.text_byte;
        held_count++;
        if (held_count == plen)
        begin
            same = 1'b1;
            for (int i = 0; i < plen; i++)
                if (held_bytes[i] != pat_bytes_r[8*i +: 8])
                    same = 1'b0;
            if (same)
            begin
                for (int i = 0; i < rlen; i++)
                    emit(rep_bytes_r[8*i +: 8], 1'b1, item.final_byte && (i == rlen - 1));
                held_count = 0;
                if (item.final_byte && rlen == 0)
                    emit(8'h00, 1'b0, 1'b1);
                return;
            end
            emit(held_bytes[0], 1'b1, item.final_byte && (held_count == 1));
            sent++;
            for (int i = 1; i < held_count; i++)
                held_bytes[i-1] = held_bytes[i];
            held_count--;
        end
        if (item.final_byte)
        begin
            for (int i = 0; i < held_count; i++)
            begin
                emit(held_bytes[i], 1'b1, i == held_count - 1);
                sent++;
            end
            held_count = 0;
            if (sent == 0)
                emit(8'h00, 1'b0, 1'b1);
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n && (!push || !full))
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                push        <= 1'b1;
                source_item <= pending_q.pop_front();
            end
            else
                push <= 1'b0;
        end
    end

    // long receiver hold
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk)
    begin : monitor_proc
        sfr_out_t want;
        if (rst_n)
        begin
            if (wr_en)
                apply_write(wr_index, wr_data);
            if (pop && !empty)
            begin
                if (rewritten_q.size() == 0)
                begin
                    $error("unexpected transfer: out_byte %0h", result_item.out_byte);
                    errors++;
                end
                else
                begin
                    want = rewritten_q.pop_front();
                    check_field("out_byte", want.out_byte, result_item.out_byte);
                    check_field("byte_present", 8'(want.byte_present),
                                8'(result_item.byte_present));
                    check_field("end_of_text", 8'(want.end_of_text),
                                8'(result_item.end_of_text));
                end
            end
            if (push && !full)
                rewrite_byte(source_item);
            if (hold_left > 0)
                pop <= 1'b0;
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_byte(logic [7:0] b, logic fin);
        sfr_in_t item;
        item.text_byte  = b;
        item.final_byte = fin;
        pending_q.push_back(item);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || push || rewritten_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // length registers get random upper data bits, only bits 3:0 count
    task automatic load_config(logic [63:0] pb, logic [3:0] pl, logic [63:0] rb,
                               logic [3:0] rl);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= REG_PATTERN_BYTES;
        wr_data  <= pb;
        @(posedge clk);
        wr_index <= REG_PATTERN_LENGTH;
        wr_data  <= {60'({$urandom, $urandom}), pl};
        @(posedge clk);
        wr_index <= REG_REPLACEMENT_BYTES;
        wr_data  <= rb;
        @(posedge clk);
        wr_index <= REG_REPLACEMENT_LENGTH;
        wr_data  <= {60'({$urandom, $urandom}), rl};
        @(posedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_random_items(int count);
        int plen;
        int run;
        int queued;
        logic [7:0] b;
        plen   = pat_len_eff();
        queued = 0;
        while (queued < count)
        begin
            case ($urandom_range(9))
                0, 1, 2: run = plen;
                3:       run = $urandom_range(plen);
                default: run = 0;
            endcase
            if (run == 0)
            begin
                if ($urandom_range(1))
                    b = pat_bytes_r[8*$urandom_range(plen - 1) +: 8];
                else
                    b = 8'($urandom);
                queue_byte(b, $urandom_range(11) == 0);
                queued++;
            end
            for (int i = 0; i < run; i++)
            begin
                queue_byte(pat_bytes_r[8*i +: 8], (i == run - 1) && ($urandom_range(4) == 0));
                queued++;
            end
        end
    endtask

    initial
    begin
        logic [3:0] pl;
        logic [3:0] rl;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: single zero byte pattern, matches deleted
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h42, 1'b1);
        drain();

        // match mid-text, on final byte, window flush, text left open
        load_config(64'h6261, 4'd2, 64'h5A5958, 4'd3);
        queue_byte(8'h78, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b1);
        queue_byte(8'h61, 1'b1);
        queue_byte(8'h61, 1'b0);
        drain();

        // zero pattern length and oversized replacement length
        load_config(64'hFF, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd15);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h01, 1'b1);
        drain();

        // oversized pattern length, deleting match on the final byte
        load_config(64'hFF00_FF00_FF00_FF00, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        for (int i = 0; i < 8; i++)
            queue_byte((i % 2) ? 8'hFF : 8'h00, i == 7);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pl = (p == 0) ? 4'd1 : (p == 1) ? 4'd8 : 4'($urandom_range(15));
            rl = (p == 2) ? 4'd0 : (p == 3) ? 4'd8 : 4'($urandom_range(15));
            load_config({$urandom, $urandom}, pl, {$urandom, $urandom}, rl);
            send_idle_pct  = send_modes[p % 4];
            recv_stall_pct = recv_modes[p % 4];
            if (p == 4)
                hold_req++;
            queue_random_items(PHASE_ITEMS);
            drain();
        end

        // close any open text
        queue_byte(8'($urandom), 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- stream_find_replace_core.f -----
sv/sfr_pkg.sv
sv/sfr_front.sv
sv/sfr_cmd_queue.sv
sv/sfr_back.sv
sv/stream_find_replace_core.sv
sim/tb_top.sv
